// File: src/afhp_pkg.sv
// shared types and constants for the audio frame header parser
package afhp_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SMALL    = 3'd1;
  localparam logic [2:0] ST_V2_SHORT = 3'd2;
  localparam logic [2:0] ST_V2_BAD   = 3'd3;
  localparam logic [2:0] ST_V2_SIZE  = 3'd4;
  localparam logic [2:0] ST_V3_TYPE  = 3'd5;
  localparam logic [2:0] ST_V3_SIZE  = 3'd6;

  localparam logic [1:0] PROTO_V2    = 2'd2;
  localparam logic [1:0] PROTO_RESET = 2'd3;

  localparam logic [15:0] V2_HDR_LEN = 16'd16;
  localparam logic [15:0] V3_HDR_LEN = 16'd4;
  localparam logic [15:0] V2_VERSION = 16'd2;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] frame_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       frame_type;
    logic       frame_done;
    logic [2:0] status;
  } out_item_t;

  // one classified byte on its way from the front to the back
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] idx;
    logic [15:0] len;
    logic        first;
    logic        last;
    logic        fmt_long;
    logic [2:0]  short_code;
  } queue_entry_t;

endpackage

// File: src/afhp_front.sv
// front end: accepts bytes, tracks frame position, classifies length
module afhp_front #(
  parameter int unsigned MAX_FRAME_BYTES = 65535
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [1:0]             cfg_write_data,
  input  logic                   frame_valid,
  input  afhp_pkg::in_item_t     frame_data,
  input  logic                   push_ready,
  output logic                   push,
  output afhp_pkg::queue_entry_t entry
);
  import afhp_pkg::*;

  localparam logic [15:0] MAX_LEN = 16'(MAX_FRAME_BYTES);

  logic [1:0]  protocol_version;
  logic [15:0] idx;
  logic [15:0] idx_next;
  logic        fmt_long;
  logic        cur_fmt;
  logic [15:0] len_sat;
  logic        last;

  assign push = frame_valid && push_ready;

  always_comb begin
    if (frame_data.frame_length == 16'd0) begin
      len_sat = 16'd1;
    end else if (frame_data.frame_length > MAX_LEN) begin
      len_sat = MAX_LEN;
    end else begin
      len_sat = frame_data.frame_length;
    end
    // format is latched on the first byte of each frame
    cur_fmt  = (idx == 16'd0) ? (protocol_version == PROTO_V2) : fmt_long;
    last     = ({1'b0, idx} + 17'd1) >= {1'b0, len_sat};
    idx_next = last ? 16'd0 : idx + 16'd1;

    entry.data_byte = frame_data.data_byte;
    entry.idx       = idx;
    entry.len       = len_sat;
    entry.first     = (idx == 16'd0);
    entry.last      = last;
    entry.fmt_long  = cur_fmt;
    if (len_sat < V3_HDR_LEN) begin
      entry.short_code = ST_SMALL;
    end else if (cur_fmt && len_sat < V2_HDR_LEN) begin
      entry.short_code = ST_V2_SHORT;
    end else begin
      entry.short_code = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_version <= PROTO_RESET;
      idx              <= 16'd0;
      fmt_long         <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        protocol_version <= cfg_write_data;
      end
      if (push) begin
        idx      <= idx_next;
        fmt_long <= cur_fmt;
      end
    end
  end

endmodule

// File: src/afhp_queue.sv
// short queue between the front and the back
module afhp_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  afhp_pkg::queue_entry_t push_entry,
  output logic                   push_ready,
  input  logic                   pop,
  output logic                   pop_valid,
  output afhp_pkg::queue_entry_t pop_entry
);
  import afhp_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  queue_entry_t     mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: src/afhp_back.sv
// back end: header parsing, checks, payload pass-through and result register
module afhp_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pop_valid,
  input  afhp_pkg::queue_entry_t pop_entry,
  output logic                   pop,
  output logic                   result_valid,
  input  logic                   result_ready,
  output afhp_pkg::out_item_t    result_data
);
  import afhp_pkg::*;

  logic [15:0] header_version;
  logic [15:0] header_type;
  logic [31:0] declared_size;
  logic [2:0]  error_code;

  logic [15:0] hv_base, ht_base;
  logic [31:0] ds_base;
  logic [2:0]  ec_base;
  logic [15:0] header_version_next;
  logic [15:0] header_type_next;
  logic [31:0] declared_size_next;
  logic [2:0]  error_code_next;
  logic [15:0] hdr_len;
  logic [15:0] rel_idx;
  logic        pv;
  logic        emit;
  logic [2:0]  status_next;
  out_item_t   result_next;

  always_comb begin
    hv_base = pop_entry.first ? 16'd0 : header_version;
    ht_base = pop_entry.first ? 16'd0 : header_type;
    ds_base = pop_entry.first ? 32'd0 : declared_size;
    ec_base = pop_entry.first ? ST_OK : error_code;

    header_version_next = hv_base;
    header_type_next    = ht_base;
    declared_size_next  = ds_base;
    error_code_next     = ec_base;

    if (pop_entry.fmt_long) begin
      hdr_len = V2_HDR_LEN;
      if (pop_entry.idx < 16'd2) begin
        header_version_next = {hv_base[7:0], pop_entry.data_byte};
      end else if (pop_entry.idx < 16'd4) begin
        header_type_next = {ht_base[7:0], pop_entry.data_byte};
      end else if (pop_entry.idx >= 16'd12 && pop_entry.idx < 16'd16) begin
        declared_size_next = {ds_base[23:0], pop_entry.data_byte};
      end
      if (pop_entry.idx == 16'd15) begin
        if (header_version_next != V2_VERSION || header_type_next > 16'd1) begin
          error_code_next = ST_V2_BAD;
        end else if (({1'b0, declared_size_next} + 33'd16) > {17'd0, pop_entry.len}) begin
          error_code_next = ST_V2_SIZE;
        end
      end
    end else begin
      hdr_len = V3_HDR_LEN;
      if (pop_entry.idx == 16'd0) begin
        header_type_next = {8'd0, pop_entry.data_byte};
      end else if (pop_entry.idx == 16'd2 || pop_entry.idx == 16'd3) begin
        declared_size_next = {16'd0, ds_base[7:0], pop_entry.data_byte};
      end
      if (pop_entry.idx == 16'd3) begin
        if (header_type_next > 16'd1) begin
          error_code_next = ST_V3_TYPE;
        end else if (({1'b0, declared_size_next} + 33'd4) > {17'd0, pop_entry.len}) begin
          error_code_next = ST_V3_SIZE;
        end
      end
    end

    rel_idx = pop_entry.idx - hdr_len;
    pv = (error_code_next == ST_OK) && (pop_entry.idx >= hdr_len)
         && ({16'd0, rel_idx} < declared_size_next);

    // short-frame codes win over header check results
    if (!pop_entry.last) begin
      status_next = ST_OK;
    end else if (pop_entry.short_code != ST_OK) begin
      status_next = pop_entry.short_code;
    end else begin
      status_next = error_code_next;
    end

    emit = pv || pop_entry.last;

    result_next.payload_byte  = pv ? pop_entry.data_byte : 8'd0;
    result_next.payload_valid = pv;
    result_next.frame_type    = (pv || (pop_entry.last && status_next == ST_OK))
                                ? header_type_next[0] : 1'b0;
    result_next.frame_done    = pop_entry.last;
    result_next.status        = status_next;

    // an item that yields nothing never waits on the result side
    pop = pop_valid && (!emit || !result_valid || result_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_version <= 16'd0;
      header_type    <= 16'd0;
      declared_size  <= 32'd0;
      error_code     <= ST_OK;
      result_valid   <= 1'b0;
    end else begin
      if (pop) begin
        header_version <= header_version_next;
        header_type    <= header_type_next;
        declared_size  <= declared_size_next;
        error_code     <= error_code_next;
      end
      if (pop && emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      result_data <= result_next;
    end
  end

endmodule

// File: src/audio_frame_header_parser_unit.sv
// top level of the audio frame header parser
// Takes one frame byte per clock with the frame length alongside and parses a
// sixteen-byte (format 2) or four-byte (format 3) header, chosen by the
// protocol register at the first byte of each frame. Payload bytes of valid
// frames come out one per clock, trailing bytes are dropped, and the last
// byte of every frame gives an item with frame_done and the status. A byte is
// accepted every clock while the result side keeps up; a byte that gives a
// result passes through the queue and is then written to the output
// register. The front end feeds a two-entry queue, and the back end drains
// it at one entry per clock into a single output register, so a stalled
// result holds the back end while the queue still takes up to two more
// bytes.
module audio_frame_header_parser_unit #(
  parameter int unsigned MAX_FRAME_BYTES = 65535
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [1:0]          cfg_write_data,
  input  logic                frame_valid,
  output logic                frame_ready,
  input  afhp_pkg::in_item_t  frame_data,
  output logic                result_valid,
  input  logic                result_ready,
  output afhp_pkg::out_item_t result_data
);
  import afhp_pkg::*;

  logic         push;
  logic         push_ready;
  queue_entry_t push_entry;
  logic         pop;
  logic         pop_valid;
  queue_entry_t pop_entry;

  assign frame_ready = push_ready;

  afhp_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .frame_valid   (frame_valid),
    .frame_data    (frame_data),
    .push_ready    (push_ready),
    .push          (push),
    .entry         (push_entry)
  );

  afhp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .push_ready(push_ready),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry)
  );

  afhp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_entry   (pop_entry),
    .pop         (pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_data (result_data)
  );

endmodule

// File: src/afhp_checker.sv
// port-level checks for the audio frame header parser, bound to the top level
module afhp_checker (
  input logic                clk,
  input logic                rst,
  input logic                result_valid,
  input logic                result_ready,
  input afhp_pkg::out_item_t result_data
);
  import afhp_pkg::*;

  // a stalled result item holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("result item changed while stalled");

  a_status_only_at_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_data.frame_done |-> result_data.status == ST_OK)
    else $error("status set on an item that does not end a frame");

  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_data.payload_valid |-> result_data.payload_byte == 8'd0)
    else $error("payload byte not zero without payload_valid");

  // type is only shown with a payload byte or a clean frame end
  a_type_masked: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_data.payload_valid && result_data.status != ST_OK
    |-> !result_data.frame_type)
    else $error("frame type shown on an item with an error and no payload");

  a_item_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_data.payload_valid || result_data.frame_done)
    else $error("result item carries neither payload nor frame end");

endmodule

bind audio_frame_header_parser_unit afhp_checker u_afhp_checker (.*);
